@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_HOLDS(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);

`else

`define ASSERT_HOLDS(name, clk, rstn, prop, msg)

`define ASSERT_NEXT(name, clk, rstn, pre, post, msg)

`endif

`endif

@@ sv/fvn_pkg.sv @@
package fvn_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int OCT_W       = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int CNT_W       = $clog2(MAX_OCTAVES + 1);

  // Octave value is Q1.24 (25 bits signed), amplitude at most 18 bits.
  localparam int SUM_W       = 44 + OCT_W;
  localparam int NORM_W      = 18 + CNT_W;
  localparam int NORM_SHIFT  = 9;
  localparam int DEN_W       = NORM_W + NORM_SHIFT;
  localparam int DCNT_W      = $clog2(SUM_W);

  localparam int MUL_W       = 33;
  localparam int PROD_W      = 2 * MUL_W;

  localparam int NUM_REGS    = 5;
  localparam int ADDR_W      = $clog2(NUM_REGS) + 2;
  localparam int IDX_W       = ADDR_W - 2;

  localparam logic [31:0] HASH_X    = 32'd374761393;
  localparam logic [31:0] HASH_Y    = 32'd668265263;
  localparam logic [31:0] HASH_S    = 32'd2246822519;
  localparam logic [31:0] HASH_M    = 32'd1274126177;
  localparam logic [31:0] HASH_XY   = HASH_X + HASH_Y;
  localparam logic [31:0] SEED_STEP = 32'd7919;
  localparam int          MIX_SH_A  = 13;
  localparam int          MIX_SH_B  = 16;

  localparam logic [17:0] EASE_K    = 18'd196608;
  localparam logic [17:0] AMP_ONE   = 18'd65536;
  localparam logic [17:0] AMP_MAX   = 18'h3FFFF;
  localparam logic [23:0] FREQ_MAX  = 24'hFFFFFF;

  localparam int Q_POS_MAX = 32767;
  localparam int Q_NEG_MAG = 32768;

  localparam logic [3:0]  RST_OCT_CNT   = 4'd1;
  localparam logic [23:0] RST_BASE_FREQ = 24'd65536;
  localparam logic [23:0] RST_LACUN     = 24'd131072;
  localparam logic [17:0] RST_GAIN      = 18'd32768;
  localparam logic [31:0] RST_SEED      = 32'd0;

  typedef enum logic [IDX_W-1:0] {
    REG_OCT_CNT   = 3'd0,
    REG_BASE_FREQ = 3'd1,
    REG_LACUN     = 3'd2,
    REG_GAIN      = 3'd3,
    REG_SEED      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]  oct_cnt;
    logic [23:0] base_freq;
    logic [23:0] lacunarity;
    logic [17:0] gain;
    logic [31:0] seed;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PX,
    ST_PY,
    ST_U1,
    ST_V1,
    ST_U2,
    ST_V2,
    ST_HX,
    ST_HY,
    ST_HS,
    ST_HB,
    ST_C00,
    ST_C10,
    ST_C01,
    ST_C11,
    ST_LO,
    ST_HI,
    ST_HIC,
    ST_VAL,
    ST_NV,
    ST_ACC,
    ST_FQ,
    ST_AMP,
    ST_NEXT,
    ST_DIV,
    ST_OUT
  } state_e;

  function automatic logic [31:0] hash_mix(input logic [31:0] h);
    return h ^ (h >> MIX_SH_A);
  endfunction

  function automatic logic [23:0] hash_fin(input logic [31:0] p);
    logic [31:0] t;
    t = p ^ (p >> MIX_SH_B);
    return t[23:0];
  endfunction

endpackage

@@ sv/fvn_cfg.sv @@
module fvn_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fvn_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output fvn_pkg::cfg_t              cfg_o
);

  fvn_pkg::cfg_t            cfg_q;
  logic                     wr_en;
  logic [fvn_pkg::IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[fvn_pkg::ADDR_W-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.oct_cnt    <= fvn_pkg::RST_OCT_CNT;
      cfg_q.base_freq  <= fvn_pkg::RST_BASE_FREQ;
      cfg_q.lacunarity <= fvn_pkg::RST_LACUN;
      cfg_q.gain       <= fvn_pkg::RST_GAIN;
      cfg_q.seed       <= fvn_pkg::RST_SEED;
    end else if (wr_en) begin
      unique case (idx)
        fvn_pkg::REG_OCT_CNT:   cfg_q.oct_cnt    <= pwdata[3:0];
        fvn_pkg::REG_BASE_FREQ: cfg_q.base_freq  <= pwdata[23:0];
        fvn_pkg::REG_LACUN:     cfg_q.lacunarity <= pwdata[23:0];
        fvn_pkg::REG_GAIN:      cfg_q.gain       <= pwdata[17:0];
        fvn_pkg::REG_SEED:      cfg_q.seed       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fvn_pkg::REG_OCT_CNT:   prdata = {28'd0, cfg_q.oct_cnt};
      fvn_pkg::REG_BASE_FREQ: prdata = {8'd0, cfg_q.base_freq};
      fvn_pkg::REG_LACUN:     prdata = {8'd0, cfg_q.lacunarity};
      fvn_pkg::REG_GAIN:      prdata = {14'd0, cfg_q.gain};
      fvn_pkg::REG_SEED:      prdata = cfg_q.seed;
      default:                prdata = 32'd0;
    endcase
  end

endmodule

@@ sv/fvn_mul.sv @@
module fvn_mul (
  input  logic                               clk_i,
  input  logic signed [fvn_pkg::MUL_W-1:0]   op_a_i,
  input  logic signed [fvn_pkg::MUL_W-1:0]   op_b_i,
  output logic signed [fvn_pkg::PROD_W-1:0]  prod_o
);

  logic signed [fvn_pkg::PROD_W-1:0] prod_q;

  // Operands are sign-extended by the caller; unsigned values carry a zero top bit.
  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

@@ sv/fvn_div.sv @@
`include "assert_macros.svh"

module fvn_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [fvn_pkg::SUM_W-1:0]  sum_i,
  input  logic        [fvn_pkg::NORM_W-1:0] norm_i,
  output logic                              done_o,
  output logic signed [15:0]                quot_o
);

  logic                        busy_q;
  logic                        done_q;
  logic                        neg_q;
  logic [fvn_pkg::DCNT_W-1:0]  cnt_q;
  logic [fvn_pkg::SUM_W-1:0]   dq_q;
  logic [fvn_pkg::DEN_W-1:0]   rem_q;
  logic [fvn_pkg::DEN_W-1:0]   den_q;
  logic [fvn_pkg::DEN_W:0]     trial;
  logic [fvn_pkg::DEN_W:0]     diff;
  logic                        ge;
  logic                        last;

  assign trial = {rem_q, dq_q[fvn_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});
  assign last  = (cnt_q == fvn_pkg::DCNT_W'(fvn_pkg::SUM_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring division of the magnitude, one quotient bit per cycle. The
  // quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= sum_i[fvn_pkg::SUM_W-1];
      dq_q  <= sum_i[fvn_pkg::SUM_W-1] ? fvn_pkg::SUM_W'(-sum_i) : fvn_pkg::SUM_W'(sum_i);
      rem_q <= '0;
      den_q <= {norm_i, {fvn_pkg::NORM_SHIFT{1'b0}}};
    end else if (busy_q) begin
      dq_q  <= {dq_q[fvn_pkg::SUM_W-2:0], ge};
      rem_q <= ge ? diff[fvn_pkg::DEN_W-1:0] : trial[fvn_pkg::DEN_W-1:0];
    end
  end

  always_comb begin
    if (!neg_q) begin
      quot_o = (dq_q > fvn_pkg::SUM_W'(fvn_pkg::Q_POS_MAX)) ? 16'sh7FFF : dq_q[15:0];
    end else begin
      quot_o = (dq_q > fvn_pkg::SUM_W'(fvn_pkg::Q_NEG_MAG)) ? 16'sh8000
                                                           : (~dq_q[15:0]) + 16'd1;
    end
  end

  assign done_o = done_q;

  `ASSERT_HOLDS(a_div_start_idle, clk_i, rst_ni, start_i |-> !busy_q, "divider restarted while busy")
  `ASSERT_NEXT(a_div_done_after_last, clk_i, rst_ni, (busy_q && last), (done_q && !busy_q), "divider did not finish after last bit")

endmodule

@@ sv/fractal_value_noise_2d.sv @@
// Each item runs its octaves in turn, the octave count clamped to 1..MAX_OCTAVES, and
// then a division; the result goes out on m_axis. One item in flight: the next item is
// accepted only after the previous result has been loaded into the output register.
// The work runs on the shared 33x33 multiplier (19 products per octave) and the
// one-bit-per-cycle divider that normalises the sum. Reset is asynchronous and active
// low; it restores the register defaults and leaves the block idle with no result pending.
`include "assert_macros.svh"

module fractal_value_noise_2d (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // s_axis_tdata: x_coord [31:0], y_coord [63:32]
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,
  // m_axis_tdata: noise_value [15:0]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fvn_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  fvn_pkg::cfg_t   cfg;
  fvn_pkg::state_e state_q, state_d;

  logic signed [fvn_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [fvn_pkg::PROD_W-1:0] prod;

  logic signed [31:0]          x_q, y_q;
  logic [23:0]                 fq_q;
  logic [17:0]                 amp_q;
  logic [31:0]                 seed_oct_q;
  logic [fvn_pkg::OCT_W-1:0]   oct_q, nlast_q, nlast_in;
  logic [31:0]                 cx_q, cy_q;
  logic [15:0]                 fx_q, fy_q, u_q, v_q;
  logic [31:0]                 usq_q, vsq_q;
  logic [31:0]                 ax_q, by_q, hbase_q;
  logic [23:0]                 c00_q, c10_q, c01_q, c11_q, lo_q, hi_q;
  logic [23:0]                 blend_add, val24;
  logic signed [24:0]          nval_q;
  logic signed [24:0]          d_lo, d_hi, d_val;
  logic signed [fvn_pkg::SUM_W-1:0] sum_q;
  logic [fvn_pkg::NORM_W-1:0]  norm_q;
  logic [4:0]                  ncl;
  logic                        accept, last_oct, div_start, div_done, out_load;
  logic signed [15:0]          quot;
  logic                        m_valid_q;
  logic [15:0]                 m_data_q;

  fvn_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fvn_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  fvn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_q),
    .norm_i  (norm_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Octave count of zero runs one octave; counts above the maximum saturate.
  always_comb begin
    if (cfg.oct_cnt == 4'd0) begin
      ncl = 5'd1;
    end else if ({1'b0, cfg.oct_cnt} > 5'(fvn_pkg::MAX_OCTAVES)) begin
      ncl = 5'(fvn_pkg::MAX_OCTAVES);
    end else begin
      ncl = {1'b0, cfg.oct_cnt};
    end
    nlast_in = fvn_pkg::OCT_W'(ncl - 5'd1);
  end

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign last_oct  = (oct_q == nlast_q);
  assign d_lo      = $signed({1'b0, c10_q}) - $signed({1'b0, c00_q});
  assign d_hi      = $signed({1'b0, c11_q}) - $signed({1'b0, c01_q});
  assign d_val     = $signed({1'b0, hi_q}) - $signed({1'b0, lo_q});
  // Interpolation a + floor((b - a) * s / 2^16); the result is known to lie in [0, 2^24).
  assign blend_add = prod[39:16];
  assign val24     = lo_q + blend_add;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fvn_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      fvn_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = fvn_pkg::ST_PX;
        end
      end
      fvn_pkg::ST_PX:  state_d = fvn_pkg::ST_PY;
      fvn_pkg::ST_PY:  state_d = fvn_pkg::ST_U1;
      fvn_pkg::ST_U1:  state_d = fvn_pkg::ST_V1;
      fvn_pkg::ST_V1:  state_d = fvn_pkg::ST_U2;
      fvn_pkg::ST_U2:  state_d = fvn_pkg::ST_V2;
      fvn_pkg::ST_V2:  state_d = fvn_pkg::ST_HX;
      fvn_pkg::ST_HX:  state_d = fvn_pkg::ST_HY;
      fvn_pkg::ST_HY:  state_d = fvn_pkg::ST_HS;
      fvn_pkg::ST_HS:  state_d = fvn_pkg::ST_HB;
      fvn_pkg::ST_HB:  state_d = fvn_pkg::ST_C00;
      fvn_pkg::ST_C00: state_d = fvn_pkg::ST_C10;
      fvn_pkg::ST_C10: state_d = fvn_pkg::ST_C01;
      fvn_pkg::ST_C01: state_d = fvn_pkg::ST_C11;
      fvn_pkg::ST_C11: state_d = fvn_pkg::ST_LO;
      fvn_pkg::ST_LO:  state_d = fvn_pkg::ST_HI;
      fvn_pkg::ST_HI:  state_d = fvn_pkg::ST_HIC;
      fvn_pkg::ST_HIC: state_d = fvn_pkg::ST_VAL;
      fvn_pkg::ST_VAL: state_d = fvn_pkg::ST_NV;
      fvn_pkg::ST_NV:  state_d = fvn_pkg::ST_ACC;
      fvn_pkg::ST_ACC: state_d = fvn_pkg::ST_FQ;
      fvn_pkg::ST_FQ:  state_d = fvn_pkg::ST_AMP;
      fvn_pkg::ST_AMP: state_d = fvn_pkg::ST_NEXT;
      fvn_pkg::ST_NEXT: begin
        if (last_oct) begin
          div_start = 1'b1;
          state_d   = fvn_pkg::ST_DIV;
        end else begin
          state_d = fvn_pkg::ST_PX;
        end
      end
      fvn_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = fvn_pkg::ST_OUT;
        end
      end
      fvn_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = fvn_pkg::ST_IDLE;
        end
      end
      default: state_d = fvn_pkg::ST_IDLE;
    endcase
  end

  // Operands of the shared multiplier; its product is consumed in the following state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      fvn_pkg::ST_PX: begin
        mul_a = {x_q[31], x_q};
        mul_b = {9'd0, fq_q};
      end
      fvn_pkg::ST_PY: begin
        mul_a = {y_q[31], y_q};
        mul_b = {9'd0, fq_q};
      end
      fvn_pkg::ST_U1: begin
        mul_a = {17'd0, fx_q};
        mul_b = {17'd0, fx_q};
      end
      fvn_pkg::ST_V1: begin
        mul_a = {17'd0, fy_q};
        mul_b = {17'd0, fy_q};
      end
      fvn_pkg::ST_U2: begin
        mul_a = {1'b0, usq_q};
        mul_b = {15'd0, fvn_pkg::EASE_K - {1'b0, fx_q, 1'b0}};
      end
      fvn_pkg::ST_V2: begin
        mul_a = {1'b0, vsq_q};
        mul_b = {15'd0, fvn_pkg::EASE_K - {1'b0, fy_q, 1'b0}};
      end
      fvn_pkg::ST_HX: begin
        mul_a = {1'b0, cx_q};
        mul_b = {1'b0, fvn_pkg::HASH_X};
      end
      fvn_pkg::ST_HY: begin
        mul_a = {1'b0, cy_q};
        mul_b = {1'b0, fvn_pkg::HASH_Y};
      end
      fvn_pkg::ST_HS: begin
        mul_a = {1'b0, seed_oct_q};
        mul_b = {1'b0, fvn_pkg::HASH_S};
      end
      // Neighbouring corners differ from the base corner by a constant in the hash sum.
      fvn_pkg::ST_C00: begin
        mul_a = {1'b0, fvn_pkg::hash_mix(hbase_q)};
        mul_b = {1'b0, fvn_pkg::HASH_M};
      end
      fvn_pkg::ST_C10: begin
        mul_a = {1'b0, fvn_pkg::hash_mix(hbase_q + fvn_pkg::HASH_X)};
        mul_b = {1'b0, fvn_pkg::HASH_M};
      end
      fvn_pkg::ST_C01: begin
        mul_a = {1'b0, fvn_pkg::hash_mix(hbase_q + fvn_pkg::HASH_Y)};
        mul_b = {1'b0, fvn_pkg::HASH_M};
      end
      fvn_pkg::ST_C11: begin
        mul_a = {1'b0, fvn_pkg::hash_mix(hbase_q + fvn_pkg::HASH_XY)};
        mul_b = {1'b0, fvn_pkg::HASH_M};
      end
      fvn_pkg::ST_LO: begin
        mul_a = {{8{d_lo[24]}}, d_lo};
        mul_b = {17'd0, u_q};
      end
      fvn_pkg::ST_HI: begin
        mul_a = {{8{d_hi[24]}}, d_hi};
        mul_b = {17'd0, u_q};
      end
      fvn_pkg::ST_VAL: begin
        mul_a = {{8{d_val[24]}}, d_val};
        mul_b = {17'd0, v_q};
      end
      fvn_pkg::ST_ACC: begin
        mul_a = {{8{nval_q[24]}}, nval_q};
        mul_b = {15'd0, amp_q};
      end
      fvn_pkg::ST_FQ: begin
        mul_a = {9'd0, fq_q};
        mul_b = {9'd0, cfg.lacunarity};
      end
      fvn_pkg::ST_AMP: begin
        mul_a = {15'd0, amp_q};
        mul_b = {15'd0, cfg.gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q   <= '0;
      nlast_q <= '0;
    end else if (accept) begin
      oct_q   <= '0;
      nlast_q <= nlast_in;
    end else if (state_q == fvn_pkg::ST_NEXT && !last_oct) begin
      oct_q <= oct_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      fvn_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          x_q        <= s_axis_tdata[31:0];
          y_q        <= s_axis_tdata[63:32];
          fq_q       <= cfg.base_freq;
          amp_q      <= fvn_pkg::AMP_ONE;
          seed_oct_q <= cfg.seed;
          sum_q      <= '0;
          norm_q     <= '0;
        end
      end
      // The cell is the floor of the scaled point; the fraction keeps 16 bits.
      fvn_pkg::ST_PY: begin
        cx_q <= prod[63:32];
        fx_q <= prod[31:16];
      end
      fvn_pkg::ST_U1: begin
        cy_q <= prod[63:32];
        fy_q <= prod[31:16];
      end
      fvn_pkg::ST_V1:  usq_q   <= prod[31:0];
      fvn_pkg::ST_U2:  vsq_q   <= prod[31:0];
      fvn_pkg::ST_V2:  u_q     <= prod[47:32];
      fvn_pkg::ST_HX:  v_q     <= prod[47:32];
      fvn_pkg::ST_HY:  ax_q    <= prod[31:0];
      fvn_pkg::ST_HS:  by_q    <= prod[31:0];
      fvn_pkg::ST_HB:  hbase_q <= ax_q + by_q + prod[31:0];
      fvn_pkg::ST_C10: c00_q   <= fvn_pkg::hash_fin(prod[31:0]);
      fvn_pkg::ST_C01: c10_q   <= fvn_pkg::hash_fin(prod[31:0]);
      fvn_pkg::ST_C11: c01_q   <= fvn_pkg::hash_fin(prod[31:0]);
      fvn_pkg::ST_LO:  c11_q   <= fvn_pkg::hash_fin(prod[31:0]);
      fvn_pkg::ST_HI:  lo_q    <= c00_q + blend_add;
      fvn_pkg::ST_HIC: hi_q    <= c01_q + blend_add;
      // Twice the value less one: flipping the top bit of the doubled value.
      fvn_pkg::ST_NV:  nval_q  <= {~val24[23], val24[22:0], 1'b0};
      fvn_pkg::ST_FQ: begin
        sum_q  <= sum_q + prod[fvn_pkg::SUM_W-1:0];
        norm_q <= norm_q + fvn_pkg::NORM_W'(amp_q);
      end
      fvn_pkg::ST_AMP: begin
        fq_q <= (|prod[47:40]) ? fvn_pkg::FREQ_MAX : prod[39:16];
      end
      fvn_pkg::ST_NEXT: begin
        amp_q      <= (|prod[35:34]) ? fvn_pkg::AMP_MAX : prod[33:16];
        seed_oct_q <= seed_oct_q + fvn_pkg::SEED_STEP;
      end
      default: ;
    endcase
  end

  // Output register; a finished item waits in ST_OUT while the previous one is still held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= quot;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, !s_axis_tready, "ready still high after an item was taken")
  `ASSERT_HOLDS(a_octave_in_range, clk_i, rst_ni, (state_q != fvn_pkg::ST_IDLE) |-> (oct_q <= nlast_q), "octave index past the clamped count")
  `ASSERT_HOLDS(a_norm_nonzero, clk_i, rst_ni, div_start |-> (norm_q != '0), "normaliser zero at division start")

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 240;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 70;

  localparam fvn_pkg::cfg_t RST_CFG = '{fvn_pkg::RST_OCT_CNT, fvn_pkg::RST_BASE_FREQ,
                                        fvn_pkg::RST_LACUN, fvn_pkg::RST_GAIN,
                                        fvn_pkg::RST_SEED};

  typedef enum {RX_READY, RX_JITTER, RX_LONG} rx_mode_e;

  // Directed sample point, optionally with a result that needs no predictor.
  typedef struct {
    fvn_pkg::cfg_t regs;
    logic [31:0]   x;
    logic [31:0]   y;
    bit            pinned;
    logic [15:0]   noise;
  } probe_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [63:0]                 s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [15:0]                 m_axis_tdata;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [fvn_pkg::ADDR_W-1:0]  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  fvn_pkg::cfg_t regs = RST_CFG;
  logic [15:0]   noise_due[$];
  int            failures = 0;
  int            idle_cycles = 0;
  int            burst_left = 0;
  bit            sender_gaps = 1'b1;
  rx_mode_e      rx_mode = RX_JITTER;
  int            ready_run = 0;
  bit            ready_state = 1'b0;

  fractal_value_noise_2d dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [23:0] lattice_hash(input logic [31:0] cx, input logic [31:0] cy,
                                               input logic [31:0] sd);
    logic [31:0] h;
    h = cx * fvn_pkg::HASH_X + cy * fvn_pkg::HASH_Y + sd * fvn_pkg::HASH_S;
    h = (h ^ (h >> fvn_pkg::MIX_SH_A)) * fvn_pkg::HASH_M;
    h = h ^ (h >> fvn_pkg::MIX_SH_B);
    return h[23:0];
  endfunction

  function automatic logic [63:0] fade(input logic [15:0] f);
    logic [63:0] ff;
    ff = {48'd0, f};
    return (ff * ff * ({46'd0, fvn_pkg::EASE_K} - 2 * ff)) >> 32;
  endfunction

  function automatic logic [63:0] lerp16(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] s);
    return (a * ({46'd0, fvn_pkg::AMP_ONE} - s) + b * s) >> 16;
  endfunction

  // Value noise of one octave, Q1.24 in [-1, 1).
  function automatic longint octave_noise(input logic [63:0] sx, input logic [63:0] sy,
                                          input logic [23:0] fq, input logic [31:0] sd);
    logic [63:0] px, py, u, v, lo, hi, val;
    logic [31:0] cx, cy;
    px = sx * {40'd0, fq};
    py = sy * {40'd0, fq};
    cx = px[63:32];
    cy = py[63:32];
    u = fade(px[31:16]);
    v = fade(py[31:16]);
    lo = lerp16({40'd0, lattice_hash(cx, cy, sd)}, {40'd0, lattice_hash(cx + 32'd1, cy, sd)}, u);
    hi = lerp16({40'd0, lattice_hash(cx, cy + 32'd1, sd)},
                {40'd0, lattice_hash(cx + 32'd1, cy + 32'd1, sd)}, u);
    val = lerp16(lo, hi, v);
    return longint'(val) * 2 - 64'sd16777216;
  endfunction

  function automatic logic [15:0] fbm_noise(input logic [31:0] x, input logic [31:0] y);
    logic [63:0] sx, sy, nf, na;
    logic [23:0] fq;
    logic [17:0] amp;
    longint      acc, norm, q;
    int          octaves;
    sx = {{32{x[31]}}, x};
    sy = {{32{y[31]}}, y};
    fq = regs.base_freq;
    amp = fvn_pkg::AMP_ONE;
    acc = 0;
    norm = 0;
    octaves = int'(regs.oct_cnt);
    if (octaves < 1) octaves = 1;
    if (octaves > fvn_pkg::MAX_OCTAVES) octaves = fvn_pkg::MAX_OCTAVES;
    for (int i = 0; i < octaves; i++) begin
      acc += octave_noise(sx, sy, fq, regs.seed + 32'(i) * fvn_pkg::SEED_STEP)
             * longint'(amp);
      norm += longint'(amp);
      nf = ({40'd0, fq} * {40'd0, regs.lacunarity}) >> 16;
      fq = (nf > {40'd0, fvn_pkg::FREQ_MAX}) ? fvn_pkg::FREQ_MAX : nf[23:0];
      na = ({46'd0, amp} * {46'd0, regs.gain}) >> 16;
      amp = (na > {46'd0, fvn_pkg::AMP_MAX}) ? fvn_pkg::AMP_MAX : na[17:0];
    end
    q = acc / (norm * 512);
    if (q > fvn_pkg::Q_POS_MAX) q = fvn_pkg::Q_POS_MAX;
    if (q < -fvn_pkg::Q_NEG_MAG) q = -fvn_pkg::Q_NEG_MAG;
    return q[15:0];
  endfunction

  function automatic logic [31:0] coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom;
    if (pick < 9) return $urandom_range(0, 32'h7FFFF) - 32'h40000;
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'hFFFFFFFF;
      4: return 32'h00010000;
      default: return 32'hFFFF0000;
    endcase
  endfunction

  function automatic probe_t probe(input fvn_pkg::cfg_t c, input logic [31:0] x,
                                   input logic [31:0] y, input bit pinned,
                                   input logic [15:0] noise);
    probe_t p;
    p.regs = c;
    p.x = x;
    p.y = y;
    p.pinned = pinned;
    p.noise = noise;
    return p;
  endfunction

  task automatic write_reg(input logic [fvn_pkg::IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = '0;
    case (idx)
      fvn_pkg::REG_OCT_CNT: begin
        regs.oct_cnt = value[3:0];
        readback = {28'd0, regs.oct_cnt};
      end
      fvn_pkg::REG_BASE_FREQ: begin
        regs.base_freq = value[23:0];
        readback = {8'd0, regs.base_freq};
      end
      fvn_pkg::REG_LACUN: begin
        regs.lacunarity = value[23:0];
        readback = {8'd0, regs.lacunarity};
      end
      fvn_pkg::REG_GAIN: begin
        regs.gain = value[17:0];
        readback = {14'd0, regs.gain};
      end
      fvn_pkg::REG_SEED: begin
        regs.seed = value;
        readback = regs.seed;
      end
      default: ;
    endcase
    if (idx < fvn_pkg::NUM_REGS) begin
      @(negedge clk_i);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      if (prdata !== readback) begin
        $error("prdata: expected %0h, actual %0h", readback, prdata);
        failures++;
      end
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Bits above each register's width carry junk, which the block must drop.
  task automatic load_settings(input fvn_pkg::cfg_t c);
    write_reg(fvn_pkg::REG_OCT_CNT, (32'($urandom) << 4) | 32'(c.oct_cnt));
    write_reg(fvn_pkg::REG_BASE_FREQ, (32'($urandom) << 24) | 32'(c.base_freq));
    write_reg(fvn_pkg::REG_LACUN, (32'($urandom) << 24) | 32'(c.lacunarity));
    write_reg(fvn_pkg::REG_GAIN, (32'($urandom) << 18) | 32'(c.gain));
    write_reg(fvn_pkg::REG_SEED, c.seed);
    write_reg(fvn_pkg::IDX_W'($urandom_range(fvn_pkg::NUM_REGS, 2 ** fvn_pkg::IDX_W - 1)),
              $urandom);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (noise_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input bit pinned,
                            input logic [15:0] noise);
    logic [15:0] due;
    int          gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(1, 20) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    due = pinned ? noise : fbm_noise(x, y);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    noise_due.push_back(due);
    burst_left--;
  endtask

  always @(negedge clk_i) begin
    if (ready_run > 0) begin
      ready_run--;
    end else begin
      ready_state = (rx_mode == RX_READY) ? 1'b1 : !ready_state;
      case (rx_mode)
        RX_READY:  ready_run = 50;
        RX_JITTER: ready_run = $urandom_range(0, 3);
        default:   ready_run = ready_state ? $urandom_range(0, 5) : $urandom_range(5, 40);
      endcase
    end
    m_axis_tready <= ready_state;
  end

  always @(posedge clk_i) begin : watch
    logic [15:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (noise_due.size() == 0) begin
          $error("noise_value: expected none, actual %0d", $signed(m_axis_tdata));
          failures++;
        end else begin
          want = noise_due.pop_front();
          if (m_axis_tdata !== want) begin
            $error("noise_value: expected %0d, actual %0d", $signed(want),
                   $signed(m_axis_tdata));
            failures++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("fractal_value_noise_2d verification failed");
        $finish;
      end
    end
  end

  initial begin
    fvn_pkg::cfg_t c;
    fvn_pkg::cfg_t zero_oct, over_oct, all_max, no_freq, no_gain, no_lacun, seed_wrap, mixed;
    probe_t        probes[$];

    zero_oct = RST_CFG;
    zero_oct.oct_cnt = 4'd0;
    over_oct = RST_CFG;
    over_oct.oct_cnt = 4'hF;
    all_max = '{4'hF, fvn_pkg::FREQ_MAX, fvn_pkg::FREQ_MAX, fvn_pkg::AMP_MAX, 32'hFFFFFFFF};
    no_freq = RST_CFG;
    no_freq.base_freq = 24'd0;
    no_gain = RST_CFG;
    no_gain.oct_cnt = 4'd8;
    no_gain.gain = 18'd0;
    no_lacun = RST_CFG;
    no_lacun.oct_cnt = 4'd4;
    no_lacun.lacunarity = 24'd0;
    seed_wrap = RST_CFG;
    seed_wrap.oct_cnt = 4'd8;
    seed_wrap.seed = 32'hFFFFFFFF;
    mixed = '{4'd8, 24'h010000, 24'h020000, 18'h08000, 32'h12345678};

    // At the origin with a zero seed the only corner that counts hashes to zero,
    // so a single octave gives exactly -1.
    probes.push_back(probe(RST_CFG, 32'h00000000, 32'h00000000, 1'b1, 16'h8000));
    probes.push_back(probe(RST_CFG, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, '0));
    probes.push_back(probe(RST_CFG, 32'h80000000, 32'h80000000, 1'b0, '0));
    probes.push_back(probe(RST_CFG, 32'h80000000, 32'h7FFFFFFF, 1'b0, '0));
    probes.push_back(probe(RST_CFG, 32'hFFFFFFFF, 32'h00000001, 1'b0, '0));
    probes.push_back(probe(RST_CFG, 32'h00018000, 32'h00024000, 1'b0, '0));
    probes.push_back(probe(zero_oct, 32'h00000000, 32'h00000000, 1'b1, 16'h8000));
    probes.push_back(probe(zero_oct, 32'h00038000, 32'hFFFC8000, 1'b0, '0));
    probes.push_back(probe(over_oct, 32'h00051234, 32'h0007ABCD, 1'b0, '0));
    probes.push_back(probe(all_max, 32'h7FFFFFFF, 32'h80000000, 1'b0, '0));
    probes.push_back(probe(all_max, 32'h12345678, 32'hFFFFFFFB, 1'b0, '0));
    probes.push_back(probe(no_freq, 32'h7FFFFFFF, 32'h80000000, 1'b1, 16'h8000));
    probes.push_back(probe(no_freq, 32'hDEADBEEF, 32'h0BADF00D, 1'b1, 16'h8000));
    probes.push_back(probe('0, 32'h55555555, 32'hAAAAAAAA, 1'b1, 16'h8000));
    probes.push_back(probe(no_gain, 32'h00012345, 32'h00067890, 1'b0, '0));
    probes.push_back(probe(no_gain, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0));
    probes.push_back(probe(no_lacun, 32'h7FFFFFFF, 32'h00000000, 1'b0, '0));
    probes.push_back(probe(seed_wrap, 32'h00010000, 32'h00010000, 1'b0, '0));
    probes.push_back(probe(seed_wrap, 32'h80000000, 32'h0000FFFF, 1'b0, '0));
    probes.push_back(probe(mixed, 32'h003F1234, 32'hFFC04321, 1'b0, '0));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (probes[i]) begin
      if (probes[i].regs != regs) begin
        wait_idle();
        load_settings(probes[i].regs);
      end
      send_point(probes[i].x, probes[i].y, probes[i].pinned, probes[i].noise);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        c = all_max;
      end else if (ph == 1) begin
        c = '0;
      end else begin
        c.oct_cnt = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 2))
          0: c.base_freq = 24'($urandom);
          1: c.base_freq = 24'($urandom_range(0, 24'h40000));
          default: c.base_freq = fvn_pkg::FREQ_MAX;
        endcase
        c.lacunarity = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                   : 24'($urandom_range(24'h8000, 24'h30000));
        c.gain = ($urandom_range(0, 3) == 0) ? 18'($urandom)
                                             : 18'($urandom_range(0, 18'h10000));
        c.seed = $urandom;
      end
      rx_mode = rx_mode_e'(ph % 3);
      sender_gaps = (ph % 4) != 3;
      wait_idle();
      load_settings(c);
      repeat (PHASE_ITEMS) send_point(coord(), coord(), 1'b0, '0);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (noise_due.size() != 0) begin
      $error("noise_value: %0d results never arrived", noise_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("fractal_value_noise_2d verification clean");
    end else begin
      $display("fractal_value_noise_2d verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/fvn_pkg.sv
sv/fvn_cfg.sv
sv/fvn_mul.sv
sv/fvn_div.sv
sv/fractal_value_noise_2d.sv
test/testbench.sv
